// ===== rtl/rpc_pkg.sv =====
// Shared types, widths and the arctangent table of the point rotation pipeline.
`timescale 1ns / 1ps

package rpc_pkg;

   // Default number of CORDIC iterations (one pipeline stage each), 12 to 32.
   localparam int CORDIC_STAGES_DEF = 24;

   // Coordinate and angle widths of the stream fields.
   localparam int COORD_W = 32;
   localparam int ANGLE_W = 32;

   // Offset point minus center, kept exact.
   localparam int D_W = COORD_W + 1;

   // CORDIC vector in Q2.30 with headroom, and residual angle.
   localparam int XY_W = 33;
   localparam int Z_W = 33;
   localparam int ATAN_W = 30;

   // Sine and cosine after rounding to 29 fraction bits.
   localparam int TRIG_W = XY_W - 1;

   // Product, sum, rounding shift and final sum widths.
   localparam int PROD_W = D_W + TRIG_W;
   localparam int SUM_W = PROD_W + 1;
   localparam int RND_SHIFT = 29;
   localparam int SHR_W = SUM_W - RND_SHIFT;
   localparam int FIN_W = SHR_W + 1;

   // Stream payload widths.
   localparam int REQ_DATA_W = 4 * COORD_W + ANGLE_W;
   localparam int RSP_DATA_W = 2 * COORD_W;

   // CORDIC limit gain 0.607252935 in Q2.30.
   localparam logic signed [XY_W-1:0] GAIN_Q30 = XY_W'(32'h26DD3B6A);

   // Quadrant codes of the coarse angle reduction.
   localparam logic [1:0] QUAD_0 = 2'd0;
   localparam logic [1:0] QUAD_1 = 2'd1;
   localparam logic [1:0] QUAD_2 = 2'd2;
   localparam logic [1:0] QUAD_3 = 2'd3;

   // atan(2^-k) in binary angle units, 2^32 is one full turn.
   localparam logic [ATAN_W-1:0] ATAN_TURN [32] = '{
      30'h20000000, 30'h12E4051E, 30'h09FB385B, 30'h051111D4, 30'h028B0D43,
      30'h0145D7E1, 30'h00A2F61E, 30'h00517C55, 30'h0028BE53, 30'h00145F2F,
      30'h000A2F98, 30'h000517CC, 30'h00028BE6, 30'h000145F3, 30'h0000A2FA,
      30'h0000517D, 30'h000028BE, 30'h0000145F, 30'h00000A30, 30'h00000518,
      30'h0000028C, 30'h00000146, 30'h000000A3, 30'h00000051, 30'h00000029,
      30'h00000014, 30'h0000000A, 30'h00000005, 30'h00000003, 30'h00000001,
      30'h00000001, 30'h00000000
   };

   // Vector and residual angle of one CORDIC stage.
   typedef struct packed {
      logic signed [XY_W-1:0] x;
      logic signed [XY_W-1:0] y;
      logic signed [Z_W-1:0]  z;
      logic [1:0]             quad;
   } rpc_cordic_type;

   // Values that ride along with the angle through the CORDIC.
   typedef struct packed {
      logic signed [COORD_W-1:0] center_x;
      logic signed [COORD_W-1:0] center_y;
      logic signed [D_W-1:0]     dx;
      logic signed [D_W-1:0]     dy;
   } rpc_ctx_type;

   // One finished result.
   typedef struct packed {
      logic signed [COORD_W-1:0] rotated_x;
      logic signed [COORD_W-1:0] rotated_y;
      logic                      clipped;
   } rpc_result_type;

endpackage

// ===== rtl/rpc_cordic_stage.sv =====
// One registered CORDIC rotation iteration with a fixed shift.
`timescale 1ns / 1ps

module rpc_cordic_stage
   import rpc_pkg::*;
#(
   parameter int STAGE_IDX = 0
) (
   input  logic           clock,
   input  logic           reset,
   input  logic           en,
   input  logic           valid_in,
   input  rpc_cordic_type cord_in,
   input  rpc_ctx_type    ctx_in,
   output logic           valid_out,
   output rpc_cordic_type cord_out,
   output rpc_ctx_type    ctx_out
);

   logic                  valid_ff;
   rpc_cordic_type        cord_ff;
   rpc_cordic_type        cord_in_c;
   rpc_ctx_type           ctx_ff;
   logic signed [XY_W-1:0] x_sh;
   logic signed [XY_W-1:0] y_sh;
   logic signed [Z_W-1:0]  atan_z;

   // Arithmetic shifts of this iteration and its angle step.
   assign x_sh   = $signed(cord_in.x) >>> STAGE_IDX;
   assign y_sh   = $signed(cord_in.y) >>> STAGE_IDX;
   assign atan_z = Z_W'(ATAN_TURN[STAGE_IDX]);

   // Turn toward zero residual angle.
   always_comb begin
      cord_in_c      = cord_in;
      if (!cord_in.z[Z_W-1]) begin
         cord_in_c.x = cord_in.x - y_sh;
         cord_in_c.y = cord_in.y + x_sh;
         cord_in_c.z = cord_in.z - atan_z;
      end else begin
         cord_in_c.x = cord_in.x + y_sh;
         cord_in_c.y = cord_in.y - x_sh;
         cord_in_c.z = cord_in.z + atan_z;
      end
   end

   // Valid bit follows the stage enable.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (en) begin
         cord_ff <= cord_in_c;
         ctx_ff  <= ctx_in;
      end
   end

   assign valid_out = valid_ff;
   assign cord_out  = cord_ff;
   assign ctx_out   = ctx_ff;

endmodule

// ===== rtl/rpc_rotate.sv =====
// Rotation of the offset by sine and cosine, rounding, center add and saturation.
`timescale 1ns / 1ps

module rpc_rotate
   import rpc_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     en,
   input  logic                     valid_in,
   input  logic signed [TRIG_W-1:0] cos_in,
   input  logic signed [TRIG_W-1:0] sin_in,
   input  rpc_ctx_type              ctx_in,
   output logic                     valid_out,
   output rpc_result_type           result_out
);

   localparam logic signed [SUM_W-1:0] RND_HALF = SUM_W'(1) <<< (RND_SHIFT - 1);

   logic                     mul_valid_ff;
   logic signed [PROD_W-1:0] p_xc_ff;
   logic signed [PROD_W-1:0] p_ys_ff;
   logic signed [PROD_W-1:0] p_xs_ff;
   logic signed [PROD_W-1:0] p_yc_ff;
   rpc_ctx_type              mul_ctx_ff;

   logic                     sum_valid_ff;
   logic signed [SUM_W-1:0]  sum_x_ff;
   logic signed [SUM_W-1:0]  sum_x_in;
   logic signed [SUM_W-1:0]  sum_y_ff;
   logic signed [SUM_W-1:0]  sum_y_in;
   logic signed [COORD_W-1:0] cx_ff;
   logic signed [COORD_W-1:0] cy_ff;

   logic signed [SHR_W-1:0] shr_x;
   logic signed [SHR_W-1:0] shr_y;
   logic signed [FIN_W-1:0] fin_x;
   logic signed [FIN_W-1:0] fin_y;
   logic                    ovf_x;
   logic                    ovf_y;

   // Valid bits of the multiply and sum stages.
   always_ff @(posedge clock) begin
      if (reset) begin
         mul_valid_ff <= 1'b0;
         sum_valid_ff <= 1'b0;
      end else if (en) begin
         mul_valid_ff <= valid_in;
         sum_valid_ff <= mul_valid_ff;
      end
   end

   // Four exact products, one multiplier each.
   always_ff @(posedge clock) begin
      if (en) begin
         p_xc_ff    <= PROD_W'(ctx_in.dx) * PROD_W'(cos_in);
         p_ys_ff    <= PROD_W'(ctx_in.dy) * PROD_W'(sin_in);
         p_xs_ff    <= PROD_W'(ctx_in.dx) * PROD_W'(sin_in);
         p_yc_ff    <= PROD_W'(ctx_in.dy) * PROD_W'(cos_in);
         mul_ctx_ff <= ctx_in;
      end
   end

   // Product sums with the rounding half folded in.
   assign sum_x_in = SUM_W'(p_xc_ff) - SUM_W'(p_ys_ff) + RND_HALF;
   assign sum_y_in = SUM_W'(p_xs_ff) + SUM_W'(p_yc_ff) + RND_HALF;

   always_ff @(posedge clock) begin
      if (en) begin
         sum_x_ff <= sum_x_in;
         sum_y_ff <= sum_y_in;
         cx_ff    <= mul_ctx_ff.center_x;
         cy_ff    <= mul_ctx_ff.center_y;
      end
   end

   // Drop the fraction, add the center back.
   assign shr_x = sum_x_ff[SUM_W-1:RND_SHIFT];
   assign shr_y = sum_y_ff[SUM_W-1:RND_SHIFT];
   assign fin_x = FIN_W'(shr_x) + FIN_W'(cx_ff);
   assign fin_y = FIN_W'(shr_y) + FIN_W'(cy_ff);

   // A sum overflows when its bits from the top down to the coordinate sign bit disagree.
   assign ovf_x = !((&fin_x[FIN_W-1:COORD_W-1]) || !(|fin_x[FIN_W-1:COORD_W-1]));
   assign ovf_y = !((&fin_y[FIN_W-1:COORD_W-1]) || !(|fin_y[FIN_W-1:COORD_W-1]));

   // Clamp to the coordinate range.
   always_comb begin
      result_out.rotated_x = fin_x[COORD_W-1:0];
      result_out.rotated_y = fin_y[COORD_W-1:0];
      if (ovf_x) begin
         result_out.rotated_x = {fin_x[FIN_W-1], {(COORD_W-1){!fin_x[FIN_W-1]}}};
      end
      if (ovf_y) begin
         result_out.rotated_y = {fin_y[FIN_W-1], {(COORD_W-1){!fin_y[FIN_W-1]}}};
      end
      result_out.clipped = ovf_x || ovf_y;
   end

   assign valid_out = sum_valid_ff;

endmodule

// ===== rtl/rpc_skid.sv =====
// Output register with one skid entry; it decouples the pipeline from the result stall.
`timescale 1ns / 1ps

module rpc_skid
   import rpc_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           valid_in,
   input  rpc_result_type result_in,
   output logic           pipe_en,
   output logic           out_valid,
   input  logic           out_ready,
   output rpc_result_type result_out
);

   logic           out_valid_ff;
   logic           out_valid_in;
   logic           skid_valid_ff;
   logic           skid_valid_in;
   rpc_result_type out_ff;
   rpc_result_type out_in;
   rpc_result_type skid_ff;
   rpc_result_type skid_in;
   logic           out_free;

   // The pipeline moves only while the skid entry is empty.
   assign pipe_en  = !skid_valid_ff;
   assign out_free = !out_valid_ff || out_ready;

   // Route the finished beat into the output or the skid entry.
   always_comb begin
      out_valid_in  = out_valid_ff;
      skid_valid_in = skid_valid_ff;
      out_in        = out_ff;
      skid_in       = skid_ff;
      if (skid_valid_ff) begin
         if (out_ready) begin
            out_in        = skid_ff;
            out_valid_in  = 1'b1;
            skid_valid_in = 1'b0;
         end
      end else if (out_free) begin
         out_in       = result_in;
         out_valid_in = valid_in;
      end else if (valid_in) begin
         skid_in       = result_in;
         skid_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

   assign out_valid  = out_valid_ff;
   assign result_out = out_ff;

endmodule

// ===== rtl/rotate_point_about_center.sv =====
// Top level: pipelined rotation of a point about a center by a binary angle.
//
//  channel | direction | handshake            | payload
//  req     | in        | req_tvalid/req_tready | tdata: center_x, center_y, point_x,
//          |           |                      |        point_y, turn_angle
//  rsp     | out       | rsp_tvalid/rsp_tready | tdata: rotated_x, rotated_y; tuser: clipped
//
// One point enters per cycle while the pipeline is not stalled; the path holds one
// pipeline register per CORDIC iteration plus input, sine/cosine, multiply, sum
// and output registers.
// Reset clears every valid bit; payload registers keep their contents.
// While a result waits, one more beat parks in the skid entry, then req_tready
// falls and the whole pipeline holds until the result is taken.
`timescale 1ns / 1ps

module rotate_point_about_center
   import rpc_pkg::*;
#(
   parameter int CORDIC_STAGES = CORDIC_STAGES_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // center_x[31:0], center_y[63:32], point_x[95:64], point_y[127:96],
   // turn_angle[159:128]
   input  logic [REQ_DATA_W-1:0] req_tdata,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // rotated_x[31:0], rotated_y[63:32]
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   // clipped[0]
   output logic                  rsp_tuser
);

   logic                      pipe_en;

   logic signed [COORD_W-1:0] center_x;
   logic signed [COORD_W-1:0] center_y;
   logic signed [COORD_W-1:0] point_x;
   logic signed [COORD_W-1:0] point_y;
   logic [ANGLE_W-1:0]        turn_angle;
   logic [ANGLE_W-1:0]        ang_round;
   logic [ANGLE_W-1:0]        ang_rest;

   rpc_cordic_type            in_cord;
   rpc_ctx_type               in_ctx;
   logic                      s0_valid_ff;
   rpc_cordic_type            s0_cord_ff;
   rpc_ctx_type               s0_ctx_ff;

   logic                      st_valid [CORDIC_STAGES+1];
   rpc_cordic_type            st_cord  [CORDIC_STAGES+1];
   rpc_ctx_type               st_ctx   [CORDIC_STAGES+1];

   logic signed [XY_W-1:0]    c_full;
   logic signed [XY_W-1:0]    s_full;
   logic signed [XY_W-1:0]    c_inc;
   logic signed [XY_W-1:0]    s_inc;
   logic                      trig_valid_ff;
   logic signed [TRIG_W-1:0]  cos_ff;
   logic signed [TRIG_W-1:0]  sin_ff;
   rpc_ctx_type               trig_ctx_ff;

   logic                      fin_valid;
   rpc_result_type            fin_result;
   rpc_result_type            rsp_result;

   // Unpack the request beat.
   assign center_x   = req_tdata[COORD_W-1:0];
   assign center_y   = req_tdata[2*COORD_W-1:COORD_W];
   assign point_x    = req_tdata[3*COORD_W-1:2*COORD_W];
   assign point_y    = req_tdata[4*COORD_W-1:3*COORD_W];
   assign turn_angle = req_tdata[4*COORD_W+ANGLE_W-1:4*COORD_W];

   assign req_tready = pipe_en;

   // Nearest quadrant, residual angle and exact offset.
   assign ang_round = turn_angle + ANGLE_W'(32'h2000_0000);
   always_comb begin
      in_cord.quad    = ang_round[ANGLE_W-1:ANGLE_W-2];
      ang_rest        = turn_angle - {in_cord.quad, {(ANGLE_W-2){1'b0}}};
      in_cord.x       = GAIN_Q30;
      in_cord.y       = '0;
      in_cord.z       = Z_W'($signed(ang_rest));
      in_ctx.center_x = center_x;
      in_ctx.center_y = center_y;
      in_ctx.dx       = D_W'(point_x) - D_W'(center_x);
      in_ctx.dy       = D_W'(point_y) - D_W'(center_y);
   end

   // Input register.
   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff <= 1'b0;
      end else if (pipe_en) begin
         s0_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (pipe_en) begin
         s0_cord_ff <= in_cord;
         s0_ctx_ff  <= in_ctx;
      end
   end

   assign st_valid[0] = s0_valid_ff;
   assign st_cord[0]  = s0_cord_ff;
   assign st_ctx[0]   = s0_ctx_ff;

   // One pipeline stage per CORDIC iteration.
   for (genvar gi = 0; gi < CORDIC_STAGES; gi++) begin : g_cordic
      rpc_cordic_stage #(
         .STAGE_IDX(gi)
      ) u_stage (
         .clock    (clock),
         .reset    (reset),
         .en       (pipe_en),
         .valid_in (st_valid[gi]),
         .cord_in  (st_cord[gi]),
         .ctx_in   (st_ctx[gi]),
         .valid_out(st_valid[gi+1]),
         .cord_out (st_cord[gi+1]),
         .ctx_out  (st_ctx[gi+1])
      );
   end

   // Map back by quadrant.
   always_comb begin
      case (st_cord[CORDIC_STAGES].quad)
         QUAD_0: begin
            c_full = st_cord[CORDIC_STAGES].x;
            s_full = st_cord[CORDIC_STAGES].y;
         end
         QUAD_1: begin
            c_full = -st_cord[CORDIC_STAGES].y;
            s_full = st_cord[CORDIC_STAGES].x;
         end
         QUAD_2: begin
            c_full = -st_cord[CORDIC_STAGES].x;
            s_full = -st_cord[CORDIC_STAGES].y;
         end
         default: begin
            c_full = st_cord[CORDIC_STAGES].y;
            s_full = -st_cord[CORDIC_STAGES].x;
         end
      endcase
   end

   // Round half up to 29 fraction bits.
   assign c_inc = c_full + XY_W'(1);
   assign s_inc = s_full + XY_W'(1);

   always_ff @(posedge clock) begin
      if (reset) begin
         trig_valid_ff <= 1'b0;
      end else if (pipe_en) begin
         trig_valid_ff <= st_valid[CORDIC_STAGES];
      end
   end

   always_ff @(posedge clock) begin
      if (pipe_en) begin
         cos_ff      <= c_inc[XY_W-1:1];
         sin_ff      <= s_inc[XY_W-1:1];
         trig_ctx_ff <= st_ctx[CORDIC_STAGES];
      end
   end

   rpc_rotate u_rotate (
      .clock     (clock),
      .reset     (reset),
      .en        (pipe_en),
      .valid_in  (trig_valid_ff),
      .cos_in    (cos_ff),
      .sin_in    (sin_ff),
      .ctx_in    (trig_ctx_ff),
      .valid_out (fin_valid),
      .result_out(fin_result)
   );

   rpc_skid u_skid (
      .clock     (clock),
      .reset     (reset),
      .valid_in  (fin_valid),
      .result_in (fin_result),
      .pipe_en   (pipe_en),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .result_out(rsp_result)
   );

   // Pack the result beat.
   assign rsp_tdata = {rsp_result.rotated_y, rsp_result.rotated_x};
   assign rsp_tuser = rsp_result.clipped;

endmodule

// ===== rtl/rpc_checker.sv =====
// Port-level checks of the point rotation block and their binding.
`timescale 1ns / 1ps

module rpc_checker
   import rpc_pkg::*;
(
   input logic                  clock,
   input logic                  reset,
   input logic                  req_tvalid,
   input logic                  req_tready,
   input logic [REQ_DATA_W-1:0] req_tdata,
   input logic                  rsp_tvalid,
   input logic                  rsp_tready,
   input logic [RSP_DATA_W-1:0] rsp_tdata,
   input logic                  rsp_tuser
);

   localparam logic [COORD_W-1:0] SAT_MAX = {1'b0, {(COORD_W-1){1'b1}}};
   localparam logic [COORD_W-1:0] SAT_MIN = {1'b1, {(COORD_W-1){1'b0}}};

   // No result is shown right after reset.
   a_reset_idle: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result valid right after reset");

   // A stalled result beat stays and holds its payload.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("stalled result beat changed");

   // The input only stalls while a result waits at the output.
   a_ready_stall: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> rsp_tvalid)
      else $error("input stalled without a pending result");

   // A clipped result has a coordinate at a range limit.
   a_clip_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |->
         rsp_tdata[COORD_W-1:0] == SAT_MAX || rsp_tdata[COORD_W-1:0] == SAT_MIN ||
         rsp_tdata[2*COORD_W-1:COORD_W] == SAT_MAX ||
         rsp_tdata[2*COORD_W-1:COORD_W] == SAT_MIN)
      else $error("clipped result not at a range limit");

   // An accepted request beat carries no unknown bits.
   a_req_known: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |-> !$isunknown(req_tdata))
      else $error("accepted request beat carries unknown bits");

endmodule

bind rotate_point_about_center rpc_checker u_rpc_checker (.*);

// ===== verif/testbench.sv =====
// Self-checking testbench for the point rotation pipeline.
`timescale 1ns / 1ps

module testbench
   import rpc_pkg::*;
();

   // Build and run constants.
   localparam int STAGES = CORDIC_STAGES_DEF;
   localparam int LATENCY = STAGES + 5;
   localparam int RANDOM_PER_PHASE = 200;
   localparam int LONG_STALL_CYCLES = 4 * LATENCY + 40;
   localparam int CYCLE_LIMIT = 200000;
   localparam int N_PHASES = 3;
   localparam int SENDER_IDLE [N_PHASES] = '{11, 69, 0};
   localparam int RECEIVER_IDLE [N_PHASES] = '{69, 11, 0};

   // Coordinate extremes of the Q15.16 fields, as field values and as 64-bit bounds.
   localparam logic signed [COORD_W-1:0] C_MAX = 32'sh7FFF_FFFF;
   localparam logic signed [COORD_W-1:0] C_MIN = 32'sh8000_0000;
   localparam longint COORD_HI = 64'sd2147483647;
   localparam longint COORD_LO = -64'sd2147483648;

   // CORDIC start gain in Q2.30 and atan(2^-k) in binary angle units.
   localparam longint GAIN_UNITS = 64'sh26DD_3B6A;
   localparam longint ATAN_UNITS [32] = '{
      64'h20000000, 64'h12E4051E, 64'h09FB385B, 64'h051111D4, 64'h028B0D43,
      64'h0145D7E1, 64'h00A2F61E, 64'h00517C55, 64'h0028BE53, 64'h00145F2F,
      64'h000A2F98, 64'h000517CC, 64'h00028BE6, 64'h000145F3, 64'h0000A2FA,
      64'h0000517D, 64'h000028BE, 64'h0000145F, 64'h00000A30, 64'h00000518,
      64'h0000028C, 64'h00000146, 64'h000000A3, 64'h00000051, 64'h00000029,
      64'h00000014, 64'h0000000A, 64'h00000005, 64'h00000003, 64'h00000001,
      64'h00000001, 64'h00000000
   };

   // One request beat before packing.
   typedef struct packed {
      logic signed [COORD_W-1:0] center_x;
      logic signed [COORD_W-1:0] center_y;
      logic signed [COORD_W-1:0] point_x;
      logic signed [COORD_W-1:0] point_y;
      logic [ANGLE_W-1:0]        turn_angle;
   } rotation_req_type;

   // One directed row: request, whether the result is typed in, and that result.
   typedef struct packed {
      rotation_req_type req;
      logic             typed;
      rpc_result_type   want;
   } directed_row_type;

   localparam int N_DIRECTED = 22;
   localparam directed_row_type DIRECTED_ROWS [N_DIRECTED] = '{
      // Zero everything, and point on the center at the field extremes.
      '{'{32'sh0, 32'sh0, 32'sh0, 32'sh0, 32'h0}, 1'b1, '{32'sh0, 32'sh0, 1'b0}},
      '{'{C_MAX, C_MAX, C_MAX, C_MAX, 32'hFFFF_FFFF}, 1'b1, '{C_MAX, C_MAX, 1'b0}},
      '{'{C_MIN, C_MIN, C_MIN, C_MIN, 32'h8000_0000}, 1'b1, '{C_MIN, C_MIN, 1'b0}},
      // Half turn of the widest offset saturates both coordinates; then a point on its center.
      '{'{C_MIN, C_MIN, C_MAX, C_MAX, 32'h8000_0000}, 1'b1, '{C_MIN, C_MIN, 1'b1}},
      '{'{C_MAX, C_MAX, C_MIN, C_MIN, 32'h8000_0000}, 1'b1, '{C_MAX, C_MAX, 1'b1}},
      '{'{32'sh0ABC_DEF0, 32'shF543_2110, 32'sh0ABC_DEF0, 32'shF543_2110,
          32'h1357_9BDF}, 1'b1, '{32'sh0ABC_DEF0, 32'shF543_2110, 1'b0}},
      // Unit vector at each quadrant.
      '{'{32'sh0, 32'sh0, 32'sh0001_0000, 32'sh0, 32'h0000_0000}, 1'b0, '0},
      '{'{32'sh0, 32'sh0, 32'sh0001_0000, 32'sh0, 32'h4000_0000}, 1'b0, '0},
      '{'{32'sh0, 32'sh0, 32'sh0001_0000, 32'sh0, 32'h8000_0000}, 1'b0, '0},
      '{'{32'sh0, 32'sh0, 32'sh0001_0000, 32'sh0, 32'hC000_0000}, 1'b0, '0},
      // Angles on either side of the quadrant rounding boundaries.
      '{'{32'sh0003_0000, 32'shFFFE_0000, 32'sh0005_0000, 32'sh0007_0000,
          32'h1FFF_FFFF}, 1'b0, '0},
      '{'{32'sh0003_0000, 32'shFFFE_0000, 32'sh0005_0000, 32'sh0007_0000,
          32'h2000_0000}, 1'b0, '0},
      '{'{32'sh0003_0000, 32'shFFFE_0000, 32'sh0005_0000, 32'sh0007_0000,
          32'h5FFF_FFFF}, 1'b0, '0},
      '{'{32'sh0003_0000, 32'shFFFE_0000, 32'sh0005_0000, 32'sh0007_0000,
          32'h6000_0000}, 1'b0, '0},
      '{'{32'sh0003_0000, 32'shFFFE_0000, 32'sh0005_0000, 32'sh0007_0000,
          32'hDFFF_FFFF}, 1'b0, '0},
      '{'{32'sh0003_0000, 32'shFFFE_0000, 32'sh0005_0000, 32'sh0007_0000,
          32'hE000_0000}, 1'b0, '0},
      // Point and center at opposite corners: the offset needs 33 bits.
      '{'{C_MIN, C_MAX, C_MAX, C_MIN, 32'h4000_0000}, 1'b0, '0},
      '{'{C_MAX, C_MIN, C_MIN, C_MAX, 32'hC000_0000}, 1'b0, '0},
      // Smallest angles either way.
      '{'{32'sh0, 32'sh0, 32'sh1234_5678, 32'shEDCB_A988, 32'h0000_0001}, 1'b0, '0},
      '{'{32'sh0, 32'sh0, 32'sh1234_5678, 32'shEDCB_A988, 32'hFFFF_FFFF}, 1'b0, '0},
      // Negative coordinates, sixty degrees, and a result close to the bottom rail.
      '{'{32'shFFFF_0000, 32'shFFFF_0000, 32'shFFFD_0000, 32'sh0001_0000,
          32'h2AAA_AAAB}, 1'b0, '0},
      '{'{C_MAX, 32'sh0, 32'sh0, C_MAX, 32'h4000_0000}, 1'b0, '0}
   };

   logic                  clock;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  rsp_tuser;

   rpc_result_type expected_rotations [$];
   rpc_result_type want_rotation;
   int error_count = 0;
   int result_count = 0;
   int cycle_count = 0;
   int sender_idle_pct = 0;
   int receiver_idle_pct = 0;
   int long_stall_req = 0;
   int long_stall_ack = 0;
   int stall_left = 0;

   rotate_point_about_center #(
      .CORDIC_STAGES(STAGES)
   ) i_dut (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata),
      .rsp_tuser(rsp_tuser)
   );

   // Clock generator.
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Rounds a product sum to the coordinate grid, adds the center and saturates.
   function automatic logic signed [COORD_W-1:0] round_and_clamp(input longint sum,
         input longint center, inout logic clip);
      longint v;
      v = ((sum + 64'sh1000_0000) >>> 29) + center;
      if (v > COORD_HI) begin
         clip = 1'b1;
         v = COORD_HI;
      end else if (v < COORD_LO) begin
         clip = 1'b1;
         v = COORD_LO;
      end
      return COORD_W'(v);
   endfunction

   // Rotates the point about the center: quadrant reduction, CORDIC, exact products.
   function automatic rpc_result_type rotate_about_center(input rotation_req_type r);
      longint vec_x, vec_y, resid, step_x, step_y, cos_v, sin_v;
      longint cx, cy, dx, dy;
      logic [ANGLE_W-1:0] biased, rest;
      logic [1:0] quad;
      logic clip;
      int k;
      rpc_result_type res;
      biased = r.turn_angle + 32'h2000_0000;
      quad = biased[ANGLE_W-1:ANGLE_W-2];
      rest = r.turn_angle - {quad, 30'd0};
      resid = longint'($signed(rest));
      vec_x = GAIN_UNITS;
      vec_y = 0;
      for (int i = 0; i < STAGES; i++) begin
         k = i & 31;
         step_x = vec_x >>> k;
         step_y = vec_y >>> k;
         if (resid >= 0) begin
            vec_x -= step_y;
            vec_y += step_x;
            resid -= ATAN_UNITS[k];
         end else begin
            vec_x += step_y;
            vec_y -= step_x;
            resid += ATAN_UNITS[k];
         end
      end
      // Map the residual rotation back to the chosen quadrant.
      case (quad)
         QUAD_0: begin
            cos_v = vec_x;
            sin_v = vec_y;
         end
         QUAD_1: begin
            cos_v = -vec_y;
            sin_v = vec_x;
         end
         QUAD_2: begin
            cos_v = -vec_x;
            sin_v = -vec_y;
         end
         default: begin
            cos_v = vec_y;
            sin_v = -vec_x;
         end
      endcase
      cos_v = (cos_v + 1) >>> 1;
      sin_v = (sin_v + 1) >>> 1;
      cx = longint'(r.center_x);
      cy = longint'(r.center_y);
      dx = longint'(r.point_x) - cx;
      dy = longint'(r.point_y) - cy;
      clip = 1'b0;
      res.rotated_x = round_and_clamp(dx * cos_v - dy * sin_v, cx, clip);
      res.rotated_y = round_and_clamp(dx * sin_v + dy * cos_v, cy, clip);
      res.clipped = clip;
      return res;
   endfunction

   // Coordinate from -2^20 to 2^20 - 1 around the origin, so nothing saturates.
   function automatic logic signed [COORD_W-1:0] near_origin();
      return $signed($urandom_range(32'h001F_FFFF)) - 32'sh0010_0000;
   endfunction

   // Rail, rail or anything.
   function automatic logic signed [COORD_W-1:0] extreme_coord();
      case ($urandom_range(2))
         0: return C_MIN;
         1: return C_MAX;
         default: return $urandom;
      endcase
   endfunction

   // Random request drawn from a mix of everyday and corner shapes.
   function automatic rotation_req_type random_point();
      rotation_req_type r;
      int unsigned pick;
      pick = $urandom_range(99);
      r.center_x = $urandom;
      r.center_y = $urandom;
      r.point_x = $urandom;
      r.point_y = $urandom;
      r.turn_angle = $urandom;
      if (pick >= 30 && pick < 65) begin
         // Ordinary geometry near the origin.
         r.center_x = near_origin();
         r.center_y = near_origin();
         r.point_x = r.center_x + near_origin();
         r.point_y = r.center_y + near_origin();
      end else if (pick >= 65 && pick < 75) begin
         r.point_x = r.center_x;
         r.point_y = r.center_y;
      end else if (pick >= 75 && pick < 90) begin
         // Angle within 8 units of a quadrant rounding boundary.
         r.center_x = near_origin();
         r.center_y = near_origin();
         r.point_x = near_origin();
         r.point_y = near_origin();
         r.turn_angle = ($urandom_range(3) << 30) + 32'h2000_0000
                        + $urandom_range(16) - 8;
      end else if (pick >= 90) begin
         r.center_x = extreme_coord();
         r.center_y = extreme_coord();
         r.point_x = extreme_coord();
         r.point_y = extreme_coord();
      end
      return r;
   endfunction

   task automatic report_mismatch(input string msg);
      $display("[%0t] MISMATCH result %0d: %s", $realtime, result_count, msg);
      error_count++;
   endtask

   // Offers one request beat after random idle cycles and records its result.
   task automatic send_point(input rotation_req_type r, input logic typed,
         input rpc_result_type typed_want);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {r.turn_angle, r.point_y, r.point_x, r.center_y, r.center_x};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      expected_rotations.push_back(typed ? typed_want : rotate_about_center(r));
   endtask

   // Holds the sender until every expected result has come out.
   task automatic drain_rotations();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (expected_rotations.size() != 0) @(posedge clock);
   endtask

   // Receiver: random ready, or a long hold-off when one is requested.
   always @(posedge clock) begin
      if (long_stall_req != long_stall_ack) begin
         long_stall_ack <= long_stall_req;
         stall_left <= LONG_STALL_CYCLES;
         rsp_tready <= 1'b0;
      end else if (stall_left != 0) begin
         stall_left <= stall_left - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= receiver_idle_pct);
      end
   end

   // Result checker: each accepted beat against the oldest expectation.
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_rotations.size() == 0) begin
            report_mismatch($sformatf("unexpected beat %h/%b", rsp_tdata, rsp_tuser));
         end else begin
            want_rotation = expected_rotations.pop_front();
            if (rsp_tdata[COORD_W-1:0] !== want_rotation.rotated_x)
               report_mismatch($sformatf("rotated_x got %h want %h",
                  rsp_tdata[COORD_W-1:0], want_rotation.rotated_x));
            if (rsp_tdata[2*COORD_W-1:COORD_W] !== want_rotation.rotated_y)
               report_mismatch($sformatf("rotated_y got %h want %h",
                  rsp_tdata[2*COORD_W-1:COORD_W], want_rotation.rotated_y));
            if (rsp_tuser !== want_rotation.clipped)
               report_mismatch($sformatf("clipped got %b want %b",
                  rsp_tuser, want_rotation.clipped));
         end
         result_count++;
      end
   end

   // Watchdog.
   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("DONE: errors detected");
      $finish;
   end

   // Main sequence: reset, directed table, then random phases of idling.
   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      for (int phase = 0; phase < N_PHASES; phase++) begin
         sender_idle_pct = SENDER_IDLE[phase];
         receiver_idle_pct <= RECEIVER_IDLE[phase];
         if (phase == 0) begin
            for (int n = 0; n < N_DIRECTED; n++)
               send_point(DIRECTED_ROWS[n].req, DIRECTED_ROWS[n].typed,
                  DIRECTED_ROWS[n].want);
         end
         for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
            // Back-pressure long enough to fill the pipeline and stall the input.
            if (phase == N_PHASES - 1 && n == 20)
               long_stall_req <= long_stall_req + 1;
            send_point(random_point(), 1'b0, '0);
         end
         drain_rotations();
      end
      repeat (4 * LATENCY) @(posedge clock);
      if (error_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
rtl/rpc_pkg.sv
rtl/rpc_cordic_stage.sv
rtl/rpc_rotate.sv
rtl/rpc_skid.sv
rtl/rotate_point_about_center.sv
rtl/rpc_checker.sv
verif/testbench.sv
